[design/psfp_pkg.sv]
// Package: types, constants and helpers for the particulate sensor frame parser.
`default_nettype none
package psfp_pkg;

	localparam logic       OP_BYTE = 1'b0;
	localparam logic       OP_IDLE = 1'b1;

	localparam logic [7:0] HDR1            = 8'h42;
	localparam logic [7:0] HDR2            = 8'h4D;
	localparam logic [7:0] LEN_HI          = 8'h00;
	localparam logic [7:0] MAX_PAYLOAD_LEN = 8'd28;

	localparam int         BUF_BYTES = 32;
	localparam int         IDX_W     = $clog2(BUF_BYTES);

	localparam logic [IDX_W-1:0] OFF_PM1  = IDX_W'(6);
	localparam logic [IDX_W-1:0] OFF_PM25 = IDX_W'(8);
	localparam logic [IDX_W-1:0] OFF_PM10 = IDX_W'(10);
	localparam logic [IDX_W-1:0] OFF_C1   = IDX_W'(20);
	localparam logic [IDX_W-1:0] OFF_C25  = IDX_W'(22);
	localparam logic [IDX_W-1:0] OFF_C10  = IDX_W'(26);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [6:0] {
		PH_HEAD1 = 7'b0000001,
		PH_HEAD2 = 7'b0000010,
		PH_LENHI = 7'b0000100,
		PH_LENLO = 7'b0001000,
		PH_DATA  = 7'b0010000,
		PH_SUMHI = 7'b0100000,
		PH_SUMLO = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic [15:0] pm1_mass;
		logic [15:0] pm25_mass;
		logic [15:0] pm10_mass;
		logic [19:0] count_1um_per_litre;
		logic [19:0] count_2p5um_per_litre;
		logic [19:0] count_10um_per_litre;
	} out_t;

	typedef struct packed {
		logic [15:0] pm1;
		logic [15:0] pm25;
		logic [15:0] pm10;
		logic [15:0] c1;
		logic [15:0] c25;
		logic [15:0] c10;
	} raw_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [19:0] times_ten(input logic [15:0] w);
		logic [19:0] x;
		x = {4'b0000, w};
		return (x << 3) + (x << 1);
	endfunction

endpackage
`default_nettype wire

[design/particulate_sensor_frame_parser_top.sv]
// Top level: particulate sensor frame parser with queue-style ports.
// Throughput: one beat per cycle while full is low; full rises only when two passed frames wait in the frame queue.
// A beat that completes a valid frame writes it into the frame queue; its counts are then scaled
// by ten as it moves into the result queue, where result shows it; other beats give no result.
// Reset (arst_n low): parser hunts for a header, frame buffer zeroed, both queues empty.
`default_nettype none
module particulate_sensor_frame_parser_top (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire psfp_pkg::in_t   rx_item,
	output logic                 empty,
	input  wire logic            pop,
	output psfp_pkg::out_t       result
);

	psfp_pkg::q_stat_t  mid_stat;
	psfp_pkg::raw_t     front_raw, mid_raw;
	logic               accept, emit, mid_pop;

	assign full   = mid_stat.full;
	assign accept = push && !mid_stat.full;

	psfp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (rx_item),
		.emit   (emit),
		.raw    (front_raw)
	);

	psfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (emit),
		.wdata  (front_raw),
		.rd     (mid_pop),
		.rdata  (mid_raw),
		.stat   (mid_stat)
	);

	psfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_stat (mid_stat),
		.mid_raw  (mid_raw),
		.mid_pop  (mid_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !mid_stat.full)
		else $error("frame passed while frame queue full");

	a_emit_queued: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !mid_stat.empty)
		else $error("passed frame missing from frame queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.count_1um_per_litre <= 20'd655350
			&& result.count_10um_per_litre <= 20'd655350))
		else $error("scaled count out of range");

endmodule
`default_nettype wire

[design/psfp_front.sv]
// Front end: byte-wise header/length/checksum parser and frame buffer.
`default_nettype none
module psfp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire psfp_pkg::in_t     item,
	output logic                   emit,
	output psfp_pkg::raw_t         raw
);

	psfp_pkg::phase_t                 phase_q, phase_d;
	logic [psfp_pkg::IDX_W-1:0]       idx_q, idx_d;
	logic [psfp_pkg::IDX_W-1:0]       len_q, len_d;
	logic [15:0]                      sum_q, sum_d;
	logic [7:0]                       buf_q [psfp_pkg::BUF_BYTES];
	logic [7:0]                       buf_nx [psfp_pkg::BUF_BYTES];
	logic                             store;
	logic [psfp_pkg::IDX_W:0]         idx_inc;
	logic [psfp_pkg::IDX_W:0]         len_end;
	logic [7:0]                       b;
	logic                             is_byte;

	assign b       = item.rx_byte;
	assign is_byte = accept && (item.op == psfp_pkg::OP_BYTE);
	assign idx_inc = {1'b0, idx_q} + (psfp_pkg::IDX_W+1)'(1);
	assign len_end = {1'b0, len_q} + (psfp_pkg::IDX_W+1)'(2);

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		len_d   = len_q;
		sum_d   = sum_q;
		store   = 1'b0;
		emit    = 1'b0;
		if (accept && item.op == psfp_pkg::OP_IDLE) begin
			phase_d = psfp_pkg::PH_HEAD1;
			idx_d   = '0;
		end else if (is_byte) begin
			store   = 1'b1;
			idx_d   = idx_inc[psfp_pkg::IDX_W-1:0];
			phase_d = psfp_pkg::PH_HEAD1;
			case (phase_q)
				psfp_pkg::PH_HEAD1: begin
					if (b == psfp_pkg::HDR1) phase_d = psfp_pkg::PH_HEAD2;
				end
				psfp_pkg::PH_HEAD2: begin
					if (b == psfp_pkg::HDR2) phase_d = psfp_pkg::PH_LENHI;
				end
				psfp_pkg::PH_LENHI: begin
					if (b == psfp_pkg::LEN_HI) phase_d = psfp_pkg::PH_LENLO;
				end
				psfp_pkg::PH_LENLO: begin
					if (b <= psfp_pkg::MAX_PAYLOAD_LEN) begin
						phase_d = psfp_pkg::PH_DATA;
						len_d   = b[psfp_pkg::IDX_W-1:0];
						// bytes 0..len+1 enter the sum; the length byte only when len >= 2
						sum_d   = {8'h00, psfp_pkg::HDR1} + {8'h00, psfp_pkg::HDR2}
							+ ((b >= 8'd2) ? {8'h00, b} : 16'h0000);
					end
				end
				psfp_pkg::PH_DATA: begin
					phase_d = psfp_pkg::PH_DATA;
					if ({1'b0, idx_q} < len_end) sum_d = sum_q + {8'h00, b};
					if (idx_inc >= len_end) phase_d = psfp_pkg::PH_SUMHI;
				end
				psfp_pkg::PH_SUMHI: begin
					if (sum_q[15:8] == b) phase_d = psfp_pkg::PH_SUMLO;
				end
				psfp_pkg::PH_SUMLO: begin
					emit = (sum_q[7:0] == b);
				end
				default: begin
					store = 1'b0;
				end
			endcase
			if (phase_d == psfp_pkg::PH_HEAD1) idx_d = '0;
		end
	end

	always_comb begin
		for (int k = 0; k < psfp_pkg::BUF_BYTES; k++) begin
			buf_nx[k] = (store && idx_q == psfp_pkg::IDX_W'(k)) ? b : buf_q[k];
		end
	end

	assign raw.pm1  = {buf_nx[psfp_pkg::OFF_PM1],  buf_nx[psfp_pkg::OFF_PM1 + 1'b1]};
	assign raw.pm25 = {buf_nx[psfp_pkg::OFF_PM25], buf_nx[psfp_pkg::OFF_PM25 + 1'b1]};
	assign raw.pm10 = {buf_nx[psfp_pkg::OFF_PM10], buf_nx[psfp_pkg::OFF_PM10 + 1'b1]};
	assign raw.c1   = {buf_nx[psfp_pkg::OFF_C1],   buf_nx[psfp_pkg::OFF_C1 + 1'b1]};
	assign raw.c25  = {buf_nx[psfp_pkg::OFF_C25],  buf_nx[psfp_pkg::OFF_C25 + 1'b1]};
	assign raw.c10  = {buf_nx[psfp_pkg::OFF_C10],  buf_nx[psfp_pkg::OFF_C10 + 1'b1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= psfp_pkg::PH_HEAD1;
			idx_q   <= '0;
			len_q   <= '0;
			sum_q   <= '0;
			for (int k = 0; k < psfp_pkg::BUF_BYTES; k++) buf_q[k] <= 8'h00;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
			for (int k = 0; k < psfp_pkg::BUF_BYTES; k++) buf_q[k] <= buf_nx[k];
		end
	end

endmodule
`default_nettype wire

[design/psfp_queue.sv]
// Short queue of passed frames between the parser and the result stage.
`default_nettype none
module psfp_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr,
	input  wire psfp_pkg::raw_t     wdata,
	input  wire logic               rd,
	output psfp_pkg::raw_t          rdata,
	output psfp_pkg::q_stat_t       stat
);

	psfp_pkg::raw_t                 ent_q [psfp_pkg::QDEPTH];
	logic [psfp_pkg::QPTR_W-1:0]    wp_q, rp_q;
	logic [psfp_pkg::QCNT_W-1:0]    cnt_q;
	logic                           do_wr, do_rd;

	assign stat.full  = (cnt_q == psfp_pkg::QCNT_W'(psfp_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign rdata      = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) ent_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + psfp_pkg::QPTR_W'(1);
			if (do_rd) rp_q <= rp_q + psfp_pkg::QPTR_W'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + psfp_pkg::QCNT_W'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - psfp_pkg::QCNT_W'(1);
		end
	end

endmodule
`default_nettype wire

[design/psfp_back.sv]
// Back end: scales particle counts by ten and holds results for the consumer.
`default_nettype none
module psfp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire psfp_pkg::q_stat_t  mid_stat,
	input  wire psfp_pkg::raw_t     mid_raw,
	output logic                    mid_pop,
	input  wire logic               pop,
	output logic                    empty,
	output psfp_pkg::out_t          result
);

	psfp_pkg::out_t                 ent_q [psfp_pkg::QDEPTH];
	psfp_pkg::out_t                 conv;
	logic [psfp_pkg::QPTR_W-1:0]    wp_q, rp_q;
	logic [psfp_pkg::QCNT_W-1:0]    cnt_q;
	logic                           room, give;

	assign room    = (cnt_q != psfp_pkg::QCNT_W'(psfp_pkg::QDEPTH));
	assign mid_pop = !mid_stat.empty && room;
	assign empty   = (cnt_q == '0);
	assign give    = pop && !empty;
	assign result  = ent_q[rp_q];

	always_comb begin
		conv.pm1_mass              = mid_raw.pm1;
		conv.pm25_mass             = mid_raw.pm25;
		conv.pm10_mass             = mid_raw.pm10;
		conv.count_1um_per_litre   = psfp_pkg::times_ten(mid_raw.c1);
		conv.count_2p5um_per_litre = psfp_pkg::times_ten(mid_raw.c25);
		conv.count_10um_per_litre  = psfp_pkg::times_ten(mid_raw.c10);
	end

	always_ff @(posedge clk) begin
		if (mid_pop) ent_q[wp_q] <= conv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (mid_pop) wp_q <= wp_q + psfp_pkg::QPTR_W'(1);
			if (give) rp_q <= rp_q + psfp_pkg::QPTR_W'(1);
			if (mid_pop && !give) cnt_q <= cnt_q + psfp_pkg::QCNT_W'(1);
			else if (give && !mid_pop) cnt_q <= cnt_q - psfp_pkg::QCNT_W'(1);
		end
	end

endmodule
`default_nettype wire
